@@ design/obz_pkg.sv @@
// ----------------------------------------------------------------------------
// obz_pkg: shared types and constants for the obstacle zone counter
// Action codes, zone indexes, configuration bundle and the per-point zone
// hit record passed from the geometry pipeline to the counters.
// ----------------------------------------------------------------------------
package obz_pkg;

   localparam logic [1:0] ACT_BEGIN = 2'd0;
   localparam logic [1:0] ACT_POINT = 2'd1;
   localparam logic [1:0] ACT_LAST  = 2'd2;

   localparam logic [2:0] REG_ENABLE      = 3'd0;
   localparam logic [2:0] REG_HEIGHT_THR  = 3'd1;
   localparam logic [2:0] REG_HALF_LENGTH = 3'd2;
   localparam logic [2:0] REG_HALF_WIDTH  = 3'd3;
   localparam logic [2:0] REG_STOP_MARGIN = 3'd4;

   localparam int ZONES   = 6;
   localparam int Z_FRONT = 0;
   localparam int Z_BACK  = 1;
   localparam int Z_LEFT  = 2;
   localparam int Z_RIGHT = 3;
   localparam int Z_CW    = 4;
   localparam int Z_CCW   = 5;

   localparam logic signed [15:0] COS_RESET = 16'sd16384;

   typedef struct packed {
      logic               enable;
      logic signed [15:0] height_threshold;
      logic [15:0]        half_length;
      logic [15:0]        half_width;
      logic [15:0]        stop_margin;
   } cfg_type;

   typedef struct packed {
      logic       front;
      logic       back;
      logic       left;
      logic       right;
      logic [1:0] cw;
      logic [1:0] ccw;
   } zone_hit_type;

endpackage

@@ design/obz_geom.sv @@
// ----------------------------------------------------------------------------
// obz_geom: point geometry pipeline
// Four stages: latch word and pose, differences, products, range and band
// tests. Emits one zone hit record per word, advancing on adv.
// ----------------------------------------------------------------------------
module obz_geom
   import obz_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_load,
   input  logic [1:0]         in_action,
   input  logic signed [23:0] in_x,
   input  logic signed [23:0] in_y,
   input  logic signed [15:0] in_height,
   input  logic signed [15:0] in_cos,
   input  logic signed [15:0] in_sin,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic [1:0]         out_action,
   output zone_hit_type       out_hit
);

   // stage 1
   logic               s1_valid_ff;
   logic [1:0]         s1_action_ff;
   logic signed [23:0] s1_x_ff, s1_y_ff;
   logic signed [15:0] s1_height_ff, s1_cos_ff, s1_sin_ff;
   // pose
   logic signed [23:0] pose_x_ff, pose_y_ff;
   logic signed [15:0] pose_cos_ff, pose_sin_ff;
   // stage 2
   logic               s2_valid_ff;
   logic [1:0]         s2_action_ff;
   logic               s2_high_ff;
   logic signed [24:0] s2_dx_ff, s2_dy_ff;
   logic signed [15:0] s2_cos_ff, s2_sin_ff;
   logic signed [24:0] dx_in, dy_in;
   // stage 3
   logic               s3_valid_ff;
   logic [1:0]         s3_action_ff;
   logic               s3_high_ff;
   logic signed [49:0] s3_dxx_ff, s3_dyy_ff;
   logic signed [40:0] s3_cdx_ff, s3_sdy_ff, s3_cdy_ff, s3_sdx_ff;
   // stage 4
   logic               s4_valid_ff;
   logic [1:0]         s4_action_ff;
   zone_hit_type       s4_hit_ff;
   zone_hit_type       hit_in;
   // derived limits
   logic [16:0]        lx, ly;
   logic [33:0]        lx2_ff, ly2_ff;
   logic [34:0]        r2_ff;
   logic [50:0]        d2;
   logic signed [42:0] x2, y2, sx, sy, lxs, lys;
   logic               keep, inner_x, inner_y, back_h, front_h, right_h, left_h;

   assign lx = {1'b0, cfg.half_length} + {1'b0, cfg.stop_margin};
   assign ly = {1'b0, cfg.half_width} + {1'b0, cfg.stop_margin};

   always_ff @(posedge clock) begin
      lx2_ff <= lx * lx;
      ly2_ff <= ly * ly;
      r2_ff  <= {1'b0, lx2_ff} + {1'b0, ly2_ff};
   end

   assign dx_in = {s1_x_ff[23], s1_x_ff} - {pose_x_ff[23], pose_x_ff};
   assign dy_in = {s1_y_ff[23], s1_y_ff} - {pose_y_ff[23], pose_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         pose_x_ff   <= '0;
         pose_y_ff   <= '0;
         pose_cos_ff <= COS_RESET;
         pose_sin_ff <= '0;
      end else if (adv) begin
         s1_valid_ff <= in_load;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         if (s1_valid_ff && s1_action_ff == ACT_BEGIN) begin
            pose_x_ff   <= s1_x_ff;
            pose_y_ff   <= s1_y_ff;
            pose_cos_ff <= s1_cos_ff;
            pose_sin_ff <= s1_sin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_action_ff <= in_action;
         s1_x_ff      <= in_x;
         s1_y_ff      <= in_y;
         s1_height_ff <= in_height;
         s1_cos_ff    <= in_cos;
         s1_sin_ff    <= in_sin;

         s2_action_ff <= s1_action_ff;
         s2_high_ff   <= (s1_height_ff >= cfg.height_threshold);
         s2_dx_ff     <= dx_in;
         s2_dy_ff     <= dy_in;
         s2_cos_ff    <= pose_cos_ff;
         s2_sin_ff    <= pose_sin_ff;

         s3_action_ff <= s2_action_ff;
         s3_high_ff   <= s2_high_ff;
         s3_dxx_ff    <= s2_dx_ff * s2_dx_ff;
         s3_dyy_ff    <= s2_dy_ff * s2_dy_ff;
         s3_cdx_ff    <= s2_cos_ff * s2_dx_ff;
         s3_sdy_ff    <= s2_sin_ff * s2_dy_ff;
         s3_cdy_ff    <= s2_cos_ff * s2_dy_ff;
         s3_sdx_ff    <= s2_sin_ff * s2_dx_ff;

         s4_action_ff <= s3_action_ff;
         s4_hit_ff    <= hit_in;
      end
   end

   always_comb begin
      d2  = {1'b0, s3_dxx_ff} + {1'b0, s3_dyy_ff};
      x2  = 43'(s3_cdx_ff) + 43'(s3_sdy_ff);
      y2  = 43'(s3_cdy_ff) - 43'(s3_sdx_ff);
      sx  = $signed({13'd0, cfg.half_length, 14'd0});
      sy  = $signed({13'd0, cfg.half_width, 14'd0});
      lxs = $signed({12'd0, lx, 14'd0});
      lys = $signed({12'd0, ly, 14'd0});

      keep    = cfg.enable && s3_high_ff && (d2 <= {16'd0, r2_ff});
      inner_y = (y2 > -sy) && (y2 < sy);
      inner_x = (x2 > -sx) && (x2 < sx);
      back_h  = keep && inner_y && (x2 > -lxs) && (x2 < 0);
      front_h = keep && inner_y && (x2 > 0) && (x2 < lxs);
      right_h = keep && inner_x && (y2 > -lys) && (y2 < 0);
      left_h  = keep && inner_x && (y2 > 0) && (y2 < lys);

      hit_in.front = front_h;
      hit_in.back  = back_h;
      hit_in.left  = left_h;
      hit_in.right = right_h;
      hit_in.cw  = 2'({1'b0, back_h && (y2 < 0)})  + 2'({1'b0, front_h && !(y2 < 0)})
                 + 2'({1'b0, right_h && !(x2 < 0)}) + 2'({1'b0, left_h && (x2 < 0)});
      hit_in.ccw = 2'({1'b0, back_h && !(y2 < 0)}) + 2'({1'b0, front_h && (y2 < 0)})
                 + 2'({1'b0, right_h && (x2 < 0)})  + 2'({1'b0, left_h && !(x2 < 0)});
   end

   assign out_valid  = s4_valid_ff;
   assign out_action = s4_action_ff;
   assign out_hit    = s4_hit_ff;

endmodule

@@ design/obstacle_zone_counter.sv @@
// ----------------------------------------------------------------------------
// obstacle_zone_counter: per-frame obstacle zone counts
// Channel   Dir  Content
// req_      in   tuser: action; tdata: x, y, height, cos, sin
// rsp_      out  tdata: front, back, left, right, cw, ccw counts
// csr_      in   write enable, register index, 16-bit write data
// One word per cycle unless input stalls; geometry pipeline (products, sums,
// band tests) feeding the counters, result registered when the last point
// is taken at them. Synchronous reset restores pose, counts and registers.
// Input stalls only while a finished result is untaken and another last
// point waits at the counters.
// ----------------------------------------------------------------------------
module obstacle_zone_counter
   import obz_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // x_coord, y_coord, height, cos_heading, sin_heading
   input  logic [1:0]   req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // front, back, left, right, cw, ccw counts
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   cfg_type                cfg_ff;
   logic                   adv, accept;
   logic                   g_valid;
   logic [1:0]             g_action;
   zone_hit_type           g_hit;
   logic [COUNT_BITS-1:0]  count_ff [ZONES];
   logic [COUNT_BITS-1:0]  count_upd [ZONES];
   logic [COUNT_BITS:0]    count_sum [ZONES];
   logic [1:0]             inc [ZONES];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [95:0]            rsp_data_ff;

   assign adv        = !(g_valid && g_action == ACT_LAST && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b1;
         cfg_ff.height_threshold <= 16'sd51;
         cfg_ff.half_length      <= 16'd256;
         cfg_ff.half_width       <= 16'd256;
         cfg_ff.stop_margin      <= 16'd102;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ENABLE:      cfg_ff.enable           <= csr_wdata[0];
            REG_HEIGHT_THR:  cfg_ff.height_threshold <= csr_wdata;
            REG_HALF_LENGTH: cfg_ff.half_length      <= csr_wdata;
            REG_HALF_WIDTH:  cfg_ff.half_width       <= csr_wdata;
            REG_STOP_MARGIN: cfg_ff.stop_margin      <= csr_wdata;
            default: ;
         endcase
      end
   end

   obz_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_load    (accept),
      .in_action  (req_tuser),
      .in_x       (req_tdata[23:0]),
      .in_y       (req_tdata[47:24]),
      .in_height  (req_tdata[63:48]),
      .in_cos     (req_tdata[79:64]),
      .in_sin     (req_tdata[95:80]),
      .cfg        (cfg_ff),
      .out_valid  (g_valid),
      .out_action (g_action),
      .out_hit    (g_hit)
   );

   always_comb begin
      inc[Z_FRONT] = {1'b0, g_hit.front};
      inc[Z_BACK]  = {1'b0, g_hit.back};
      inc[Z_LEFT]  = {1'b0, g_hit.left};
      inc[Z_RIGHT] = {1'b0, g_hit.right};
      inc[Z_CW]    = g_hit.cw;
      inc[Z_CCW]   = g_hit.ccw;
      for (int i = 0; i < ZONES; i++) begin
         count_sum[i] = {1'b0, count_ff[i]} + (COUNT_BITS+1)'(inc[i]);
         count_upd[i] = count_sum[i][COUNT_BITS] ? COUNT_MAX : count_sum[i][COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_wr_en && csr_index == REG_ENABLE && !csr_wdata[0])) begin
         for (int i = 0; i < ZONES; i++) count_ff[i] <= '0;
      end else if (adv && g_valid) begin
         case (g_action) inside
            ACT_BEGIN: for (int i = 0; i < ZONES; i++) count_ff[i] <= '0;
            ACT_POINT, ACT_LAST: for (int i = 0; i < ZONES; i++) count_ff[i] <= count_upd[i];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (adv && g_valid && g_action == ACT_LAST) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (adv && g_valid && g_action == ACT_LAST) begin
         rsp_data_ff <= {16'(count_upd[Z_CCW]),   16'(count_upd[Z_CW]),
                         16'(count_upd[Z_RIGHT]), 16'(count_upd[Z_LEFT]),
                         16'(count_upd[Z_BACK]),  16'(count_upd[Z_FRONT])};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/obstacle_zone_counter_test.sv @@
// ----------------------------------------------------------------------------
// obstacle_zone_counter_test: self-checking bench for the zone counter
// Drives begin, point and last-point words on the request stream with random
// gaps, and holds off the result stream at random and once for a long stretch.
// A tally object mirrors pose, registers and the six saturating counts and
// checks every emitted count word field by field. Covers register extremes,
// band edges, odd headings and ignored action codes.
// ----------------------------------------------------------------------------
module obstacle_zone_counter_test
   import obz_pkg::*;
();

   localparam int         COUNT_BITS   = 16;
   localparam longint     COUNT_MAX    = (longint'(1) << COUNT_BITS) - 1;
   localparam logic [1:0] ACT_SPARE    = 2'd3;
   localparam logic [2:0] REG_SPARE    = 3'd7;
   localparam int         DRAIN_CYCLES = 12;
   localparam int         LONG_HOLD    = 400;
   localparam int         PHASES       = 10;
   localparam int         PHASE_WORDS  = 103;

   class zone_tally;
      bit                 enable;
      logic signed [15:0] height_thr;
      logic [15:0]        half_len;
      logic [15:0]        half_wid;
      logic [15:0]        margin;
      logic signed [23:0] veh_x;
      logic signed [23:0] veh_y;
      logic signed [15:0] veh_cos;
      logic signed [15:0] veh_sin;
      longint             counts[ZONES];
      logic [95:0]        pending_counts[$];
      int                 mismatches;

      function new();
         enable     = 1'b1;
         height_thr = 16'sd51;
         half_len   = 16'd256;
         half_wid   = 16'd256;
         margin     = 16'd102;
         veh_x      = '0;
         veh_y      = '0;
         veh_cos    = COS_RESET;
         veh_sin    = '0;
         mismatches = 0;
         clear_counts();
      endfunction

      function void clear_counts();
         foreach (counts[z]) counts[z] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            REG_ENABLE: begin
               enable = val[0];
               if (!val[0]) clear_counts();
            end
            REG_HEIGHT_THR:  height_thr = val;
            REG_HALF_LENGTH: half_len = val;
            REG_HALF_WIDTH:  half_wid = val;
            REG_STOP_MARGIN: margin = val;
            default: ;
         endcase
      endfunction

      function void bump(int z);
         if (counts[z] < COUNT_MAX) counts[z]++;
      endfunction

      function void tally_point(logic signed [23:0] px, logic signed [23:0] py,
                                logic signed [15:0] h);
         longint dx, dy, x2, y2, lx, ly, ax, ay, sx, sy;
         if (!enable) return;
         dx = longint'(px) - longint'(veh_x);
         dy = longint'(py) - longint'(veh_y);
         lx = longint'(half_len) + longint'(margin);
         ly = longint'(half_wid) + longint'(margin);
         if (dx * dx + dy * dy > lx * lx + ly * ly) return;
         if (h < height_thr) return;
         x2 = longint'(veh_cos) * dx + longint'(veh_sin) * dy;
         y2 = longint'(veh_cos) * dy - longint'(veh_sin) * dx;
         ax = x2 < 0 ? -x2 : x2;
         ay = y2 < 0 ? -y2 : y2;
         lx = lx * 16384;
         ly = ly * 16384;
         sx = longint'(half_len) * 16384;
         sy = longint'(half_wid) * 16384;
         if (ay < sy) begin
            if (x2 > -lx && x2 < 0) begin
               bump(y2 < 0 ? Z_CW : Z_CCW);
               bump(Z_BACK);
            end else if (x2 > 0 && x2 < lx) begin
               bump(y2 < 0 ? Z_CCW : Z_CW);
               bump(Z_FRONT);
            end
         end
         if (ax < sx) begin
            if (y2 > -ly && y2 < 0) begin
               bump(x2 < 0 ? Z_CCW : Z_CW);
               bump(Z_RIGHT);
            end else if (y2 > 0 && y2 < ly) begin
               bump(x2 < 0 ? Z_CW : Z_CCW);
               bump(Z_LEFT);
            end
         end
      endfunction

      function void take_word(logic [1:0] act, logic [95:0] d);
         logic [95:0] frame_counts;
         case (act)
            ACT_BEGIN: begin
               clear_counts();
               veh_x   = d[23:0];
               veh_y   = d[47:24];
               veh_cos = d[79:64];
               veh_sin = d[95:80];
            end
            ACT_POINT: tally_point(d[23:0], d[47:24], d[63:48]);
            ACT_LAST: begin
               tally_point(d[23:0], d[47:24], d[63:48]);
               foreach (counts[z]) frame_counts[z*16 +: 16] = counts[z][15:0];
               pending_counts = {pending_counts, frame_counts};
            end
            default: ;
         endcase
      endfunction

      function string zone_label(int z);
         case (z)
            Z_FRONT: return "front";
            Z_BACK:  return "back";
            Z_LEFT:  return "left";
            Z_RIGHT: return "right";
            Z_CW:    return "cw";
            default: return "ccw";
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_counts(logic [95:0] got);
         logic [95:0] want;
         if (pending_counts.size() == 0) begin
            report_mismatch("count word with no frame pending");
            return;
         end
         want = pending_counts.pop_front();
         for (int z = 0; z < ZONES; z++)
            if (got[z*16 +: 16] !== want[z*16 +: 16])
               report_mismatch($sformatf("%s count %0d, expected %0d", zone_label(z),
                                         got[z*16 +: 16], want[z*16 +: 16]));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   zone_tally tally;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   bit        hold_request = 1'b0;

   always #5 clock = ~clock;

   obstacle_zone_counter #(.COUNT_BITS(COUNT_BITS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tally.check_counts(rsp_tdata);
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct) begin
            hold = $urandom_range(10, 1) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #10000000;
      $display("FAILED: results differ");
      $finish;
   end

   function logic [95:0] pack_word(logic [23:0] x, logic [23:0] y, logic [15:0] h,
                                   logic [15:0] c, logic [15:0] s);
      return {s, c, h, y, x};
   endfunction

   task send_word(logic [1:0] act, logic [95:0] d);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tally.take_word(act, d);
      @(negedge clock);
   endtask

   task write_csr(logic [2:0] idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      tally.write_reg(idx, val);
      @(negedge clock);
   endtask

   task load_config(bit en, logic [15:0] thr, logic [15:0] hl, logic [15:0] hw,
                    logic [15:0] m);
      logic [14:0] junk;
      junk = 15'($urandom);
      write_csr(REG_ENABLE, {junk, en});
      write_csr(REG_HEIGHT_THR, thr);
      write_csr(REG_HALF_LENGTH, hl);
      write_csr(REG_HALF_WIDTH, hw);
      write_csr(REG_STOP_MARGIN, m);
      csr_wr_en <= 1'b0;
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (tally.pending_counts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function logic [15:0] pick_height();
      if ($urandom_range(99) < 70)
         return 16'(int'(tally.height_thr) + int'($urandom_range(40)) - 20);
      return 16'($urandom);
   endfunction

   function logic [95:0] near_point();
      int lx, ly, reach, dx, dy;
      lx = int'(tally.half_len) + int'(tally.margin);
      ly = int'(tally.half_wid) + int'(tally.margin);
      if ($urandom_range(99) < 30)
         reach = (tally.half_len < tally.half_wid ? int'(tally.half_len)
                                                  : int'(tally.half_wid)) + 2;
      else
         reach = (lx > ly ? lx : ly) + 2;
      dx = int'($urandom_range(2 * reach)) - reach;
      dy = int'($urandom_range(2 * reach)) - reach;
      return pack_word(tally.veh_x + 24'(dx), tally.veh_y + 24'(dy), pick_height(),
                       16'($urandom), 16'($urandom));
   endfunction

   task send_pose();
      logic [15:0] c, s;
      int pick;
      pick = $urandom_range(9);
      if (pick < 2) begin
         case ($urandom_range(3))
            0: begin c = COS_RESET;  s = '0;         end
            1: begin c = -COS_RESET; s = '0;         end
            2: begin c = '0;         s = COS_RESET;  end
            default: begin c = '0;   s = -COS_RESET; end
         endcase
      end else if (pick < 8) begin
         c = 16'(int'($urandom_range(32768)) - 16384);
         s = 16'(int'($urandom_range(32768)) - 16384);
      end else begin
         c = 16'($urandom);
         s = 16'($urandom);
      end
      send_word(ACT_BEGIN, pack_word(24'($urandom), 24'($urandom), 16'($urandom), c, s));
   endtask

   task run_traffic(int words, bit short_frames);
      int sent, npts;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 12) begin
            send_word(2'($urandom), {$urandom, $urandom, $urandom});
            sent++;
         end else begin
            if ($urandom_range(9) != 0) begin
               send_pose();
               sent++;
            end
            npts = short_frames ? $urandom_range(2) : $urandom_range(14, 1);
            repeat (npts) begin
               send_word(ACT_POINT, near_point());
               sent++;
            end
            if ($urandom_range(9) != 0) begin
               send_word(ACT_LAST, near_point());
               sent++;
            end
         end
      end
   endtask

   task phase_config(int p);
      case (p)
         0: load_config(1'b1, 16'h8000, 16'd0, 16'd0, 16'd0);
         1: load_config(1'b1, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         2: begin
            write_csr(REG_SPARE, 16'($urandom));
            load_config(1'b0, 16'd0, 16'd300, 16'd200, 16'd50);
         end
         3: load_config(1'b1, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         default: load_config($urandom_range(9) != 0,
                              16'(int'($urandom_range(600)) - 300),
                              16'($urandom_range(3000)), 16'($urandom_range(3000)),
                              16'($urandom_range(600)));
      endcase
   endtask

   function int idle_level();
      case ($urandom_range(2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   initial begin
      tally = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 20;

      // reset pose, default registers
      send_word(ACT_POINT, pack_word(24'd100, 24'd0, 16'd51, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd0, 24'd100, 16'd50, 16'd0, 16'd0));
      send_word(ACT_LAST, pack_word(24'(-100), 24'd0, 16'h7FFF, 16'd0, 16'd0));
      send_word(ACT_BEGIN, pack_word(24'h7FFFFF, 24'h800000, 16'h8000, 16'h8000, 16'h7FFF));
      send_word(ACT_POINT, pack_word(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'hFFFF, 16'hFFFF));
      send_word(ACT_LAST, pack_word(24'h800000, 24'h7FFFFF, 16'h7FFF, 16'd0, 16'd0));
      send_word(ACT_BEGIN, pack_word(24'd0, 24'd0, 16'd0, COS_RESET, 16'd0));
      send_word(ACT_POINT, pack_word(24'd358, 24'd0, 16'd51, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd357, 24'd0, 16'd51, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd0, 24'(-357), 16'd60, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd0, 24'(-358), 16'd60, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd358, 24'd358, 16'd60, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd255, 24'd255, 16'd60, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'd256, 24'd10, 16'd60, 16'd0, 16'd0));
      send_word(ACT_POINT, pack_word(24'(-10), 24'(-10), 16'd60, 16'd0, 16'd0));
      send_word(ACT_SPARE, {$urandom, $urandom, $urandom});
      send_word(ACT_LAST, pack_word(24'd0, 24'd0, 16'd51, 16'd0, 16'd0));
      send_word(ACT_BEGIN, pack_word(24'd0, 24'd0, 16'd0, 16'd0, COS_RESET));
      send_word(ACT_POINT, pack_word(24'd100, 24'd0, 16'd51, 16'd0, 16'd0));
      send_word(ACT_LAST, pack_word(24'd0, 24'd100, 16'd51, 16'd0, 16'd0));
      send_word(ACT_LAST, pack_word(24'(-100), 24'd0, 16'h8000, 16'd0, 16'd0));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         phase_config(p);
         send_idle_pct = idle_level();
         recv_idle_pct = idle_level();
         // hold the result side off while short frames keep coming
         if (p == 4) hold_request = 1'b1;
         run_traffic(PHASE_WORDS, p == 4);
         drain();
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      phase_config(PHASES);
      run_traffic(PHASE_WORDS, 1'b0);
      drain();

      if (tally.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
